// ===== src/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Shared constants, codes and types for the tick task scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

    // Table size and counter width
    localparam int MAX_TASKS  = 16;
    localparam int COUNT_BITS = 16;

    // Slot index width and used-slot count width
    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    // Common width for comparing a slot index with the slot count
    localparam int CMP_W = IDX_W + CNT_W;

    // Port field widths
    localparam int REQ_W    = 2;
    localparam int TMO_W    = 16;
    localparam int STATUS_W = 2;
    localparam int TIDX_W   = 4;
    localparam int TTOT_W   = 5;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD      = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DISPATCH = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // One task entry
    typedef struct packed {
        logic [COUNT_BITS-1:0] interval;
        logic [COUNT_BITS-1:0] remaining;
        logic [COUNT_BITS-1:0] pending;
    } entry_t;

    // Control from the sequencer to the update unit
    typedef struct packed {
        logic [REQ_W-1:0]      req;
        logic                  in_use;   // current slot below used count
        logic                  at_tail;  // current slot is the first free one
        logic                  found;    // dispatch already served
        logic [COUNT_BITS-1:0] tmo;
        logic                  periodic;
    } head_ctrl_t;

endpackage

// ===== src/tts_cell.sv =====
// ----------------------------------------------------------------------------
// tts_cell
// One storage cell of the task ring; loads its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module tts_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift,
    input  tts_pkg::entry_t d,
    output tts_pkg::entry_t q
);

    tts_pkg::entry_t entry_reg;
    tts_pkg::entry_t entry_next;

    // hold or take neighbor
    always_comb begin
        entry_next = entry_reg;
        if (shift) begin
            entry_next = d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign q = entry_reg;

endmodule

// ===== src/tts_head.sv =====
// ----------------------------------------------------------------------------
// tts_head
// Update unit at the head of the ring: count-down, add and dispatch on the
// entry passing through.
// ----------------------------------------------------------------------------
module tts_head (
    input  tts_pkg::head_ctrl_t ctrl,
    input  tts_pkg::entry_t     entry_in,
    output tts_pkg::entry_t     entry_out,
    output logic                take
);

    logic [tts_pkg::COUNT_BITS-1:0] left;
    logic                           fire;

    // tick count-down
    always_comb begin
        left = entry_in.remaining;
        fire = 1'b0;
        if (entry_in.interval != '0) begin
            left = entry_in.remaining - 1'b1;
            if (left == '0) begin
                left = entry_in.interval;
                fire = 1'b1;
            end
        end else if (entry_in.remaining != '0) begin
            left = entry_in.remaining - 1'b1;
            fire = (left == '0);
        end
    end

    // per-request update
    always_comb begin
        entry_out = entry_in;
        take      = 1'b0;
        case (ctrl.req)
            tts_pkg::REQ_TICK: begin
                if (ctrl.in_use) begin
                    entry_out.remaining = left;
                    if (fire && entry_in.pending != tts_pkg::CNT_MAX) begin
                        entry_out.pending = entry_in.pending + 1'b1;
                    end
                end
            end
            tts_pkg::REQ_ADD: begin
                if (ctrl.at_tail) begin
                    entry_out.remaining = ctrl.tmo;
                    entry_out.pending   = '0;
                    entry_out.interval  = ctrl.periodic ? ctrl.tmo : '0;
                end
            end
            tts_pkg::REQ_DISPATCH: begin
                if (ctrl.in_use && !ctrl.found && entry_in.pending != '0) begin
                    entry_out.pending = entry_in.pending - 1'b1;
                    take              = 1'b1;
                end
            end
            default: begin
                entry_out = entry_in;
            end
        endcase
    end

endmodule

// ===== src/tick_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// tick_task_scheduler
// Cooperative timer-tick task scheduler built as a rotating ring of cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request: tick, add task, or dispatch next ready
//   task. m_ channel returns one result per request: status, slot index and
//   the number of tasks in the table afterwards.
//   The task table sits in a ring of MAX_TASKS cells. Per request the ring
//   rotates once around; at each step the entry at the head goes through the
//   update unit and re-enters at the tail, so the table is back in place at
//   the end.
//   s_ready is low during the walk, so a new request is taken only after
//   the walk of the previous one has finished.
//   A new request is taken while the previous result still waits on m_.
//   If the receiver stalls, the walk holds on its last step until the
//   result register frees up; s_ready stays low meanwhile.
//   Reset (aresetn low, synchronous) empties the table and drops any result.
// ----------------------------------------------------------------------------
module tick_task_scheduler (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tts_pkg::REQ_W-1:0]     s_req_type,
    input  logic [tts_pkg::TMO_W-1:0]     s_timeout,
    input  logic                          s_periodic,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tts_pkg::STATUS_W-1:0]  m_status,
    output logic [tts_pkg::TIDX_W-1:0]    m_task_index,
    output logic [tts_pkg::TTOT_W-1:0]    m_task_total
);

    localparam int N = tts_pkg::MAX_TASKS;
    localparam logic [tts_pkg::IDX_W-1:0] LAST_K = tts_pkg::IDX_W'(N - 1);
    localparam logic [tts_pkg::CNT_W-1:0] FULL_N = tts_pkg::CNT_W'(N);

    // sequencer state
    logic                          busy_reg, busy_next;
    logic [tts_pkg::IDX_W-1:0]     k_reg, k_next;
    logic [tts_pkg::REQ_W-1:0]     req_reg, req_next;
    logic [tts_pkg::COUNT_BITS-1:0] tmo_reg, tmo_next;
    logic                          per_reg, per_next;
    logic [tts_pkg::CNT_W-1:0]     n_reg, n_next;
    logic                          found_reg, found_next;
    logic [tts_pkg::IDX_W-1:0]     idx_reg, idx_next;

    // result register
    logic                          m_valid_reg, m_valid_next;
    logic [tts_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [tts_pkg::TIDX_W-1:0]    tidx_reg, tidx_next;
    logic [tts_pkg::TTOT_W-1:0]    ttot_reg, ttot_next;

    logic                          accept;
    logic                          last;
    logic                          step;
    logic                          full;
    logic                          take;
    logic                          hit;
    logic [tts_pkg::IDX_W-1:0]     hit_idx;
    logic [tts_pkg::CMP_W-1:0]     k_cmp;
    logic [tts_pkg::CMP_W-1:0]     n_cmp;
    logic [tts_pkg::TMO_W+tts_pkg::COUNT_BITS-1:0] tmo_ext;
    logic [tts_pkg::IDX_W+tts_pkg::TIDX_W-1:0]     idx_ext;
    logic [tts_pkg::CNT_W+tts_pkg::TTOT_W-1:0]     tot_ext;

    tts_pkg::head_ctrl_t           ctrl;
    tts_pkg::entry_t               head_out;
    tts_pkg::entry_t               cell_q [N];
    tts_pkg::entry_t               cell_d [N];

    // handshake and walk control
    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign last    = (k_reg == LAST_K);
    assign step    = busy_reg && !(last && m_valid_reg && !m_ready);
    assign full    = (n_reg == FULL_N);

    // slot index vs used count
    assign k_cmp = {{tts_pkg::CNT_W{1'b0}}, k_reg};
    assign n_cmp = {{tts_pkg::IDX_W{1'b0}}, n_reg};

    assign ctrl.req      = req_reg;
    assign ctrl.in_use   = (k_cmp < n_cmp);
    assign ctrl.at_tail  = (k_cmp == n_cmp);
    assign ctrl.found    = found_reg;
    assign ctrl.tmo      = tmo_reg;
    assign ctrl.periodic = per_reg;

    tts_head u_head (
        .ctrl      (ctrl),
        .entry_in  (cell_q[0]),
        .entry_out (head_out),
        .take      (take)
    );

    // ring of cells: each loads from the next, the last from the head unit
    for (genvar i = 0; i < N; i++) begin : g_ring
        if (i == N - 1) begin : g_tail
            assign cell_d[i] = head_out;
        end else begin : g_mid
            assign cell_d[i] = cell_q[i+1];
        end
        tts_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (step),
            .d       (cell_d[i]),
            .q       (cell_q[i])
        );
    end

    // dispatch hit including the current step
    assign hit     = found_reg || take;
    assign hit_idx = take ? k_reg : idx_reg;

    assign tmo_ext = {{tts_pkg::COUNT_BITS{1'b0}}, s_timeout};

    // sequencer and result formation
    always_comb begin
        busy_next    = busy_reg;
        k_next       = k_reg;
        req_next     = req_reg;
        tmo_next     = tmo_reg;
        per_next     = per_reg;
        n_next       = n_reg;
        found_next   = found_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        tidx_next    = tidx_reg;
        ttot_next    = ttot_reg;
        idx_ext      = '0;
        tot_ext      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            busy_next  = 1'b1;
            k_next     = '0;
            req_next   = s_req_type;
            tmo_next   = tmo_ext[tts_pkg::COUNT_BITS-1:0];
            per_next   = s_periodic;
            found_next = 1'b0;
            idx_next   = '0;
        end

        if (step) begin
            k_next     = k_reg + 1'b1;
            found_next = hit;
            idx_next   = hit_idx;
            if (last) begin
                busy_next    = 1'b0;
                k_next       = '0;
                m_valid_next = 1'b1;
                status_next  = tts_pkg::ST_DONE;
                idx_ext      = '0;
                case (req_reg)
                    tts_pkg::REQ_ADD: begin
                        if (full) begin
                            status_next = tts_pkg::ST_FULL;
                        end else begin
                            idx_ext = {{tts_pkg::TIDX_W{1'b0}},
                                       n_reg[tts_pkg::IDX_W-1:0]};
                            n_next  = n_reg + 1'b1;
                        end
                    end
                    tts_pkg::REQ_DISPATCH: begin
                        if (hit) begin
                            idx_ext = {{tts_pkg::TIDX_W{1'b0}}, hit_idx};
                        end else begin
                            status_next = tts_pkg::ST_NONE;
                        end
                    end
                    default: begin
                        idx_ext = '0;
                    end
                endcase
                tidx_next = idx_ext[tts_pkg::TIDX_W-1:0];
                tot_ext   = {{tts_pkg::TTOT_W{1'b0}}, n_next};
                ttot_next = tot_ext[tts_pkg::TTOT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            k_reg       <= '0;
            n_reg       <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            k_reg       <= k_next;
            n_reg       <= n_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        tmo_reg    <= tmo_next;
        per_reg    <= per_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        tidx_reg   <= tidx_next;
        ttot_reg   <= ttot_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_task_index = tidx_reg;
    assign m_task_total = ttot_reg;

    // walk starts at slot zero after a request is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg && (k_reg == '0))
        else $error("walk did not start at slot zero");

    // used count never exceeds table size
    assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= FULL_N)
        else $error("used slot count beyond table size");

    // the walk only pauses for a blocked result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !step |-> last && m_valid_reg)
        else $error("walk stalled without a blocked result");

    // finishing the walk presents a result and frees the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && last |=> m_valid_reg && !busy_reg)
        else $error("result not presented at end of walk");

    // a dispatch is served at most once per walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && found_reg |-> !take)
        else $error("dispatch took more than one run");

endmodule
